// File: sv/ppidfd_pkg.sv
// Shared constants, configuration and command types for the filtered-derivative PID block.
`timescale 1ns / 1ps

package ppidfd_pkg;

  // Internal accumulator width and fixed-point fraction bits.
  localparam int ACC_WIDTH  = 40;
  localparam int FRAC_BITS  = 16;

  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 24;
  localparam int COEF_W     = 17;
  localparam int LIM_W      = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  // Second multiplier operand holds a gain magnitude or a filter weight up to one.
  localparam int MAG_B_W = (GAIN_W > FRAC_BITS + 1) ? GAIN_W : FRAC_BITS + 1;
  // The first operand is split into two halves that share one multiplier.
  localparam int HALF_W  = (ACC_WIDTH + 1) / 2;
  localparam int UPPER_W = ACC_WIDTH - HALF_W;
  localparam int PP_W    = HALF_W + MAG_B_W;
  localparam int PROD_W  = ACC_WIDTH + MAG_B_W;
  localparam int QUOT_W  = PROD_W - FRAC_BITS;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_FILTER_COEFF = 3'd3,
    REG_PROP_LIMIT   = 3'd4,
    REG_INTEG_BOUND  = 3'd5,
    REG_DERIV_LIMIT  = 3'd6,
    REG_OUT_LIMIT    = 3'd7
  } cfg_idx_t;

  // Products computed on the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    OP_DA = 3'd0,  // derivative input times filter weight
    OP_FB = 3'd1,  // old filtered derivative times one minus weight
    OP_PE = 3'd2,  // proportional gain times error
    OP_IA = 3'd3,  // integral gain times accumulator
    OP_DF = 3'd4   // derivative gain times new filtered derivative
  } op_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [COEF_W-1:0]        filter_coeff;
    logic [LIM_W-1:0]         prop_limit;
    logic [LIM_W-1:0]         integ_bound;
    logic [LIM_W-1:0]         deriv_limit;
    logic [LIM_W-1:0]         out_limit;
  } cfg_t;

  typedef struct packed {
    logic take_in;
    logic pre;
    logic ld_en;
    op_t  ld_op;
    logic iclamp;
    logic lo_en;
    logic hi_en;
    logic sum_pi;
    logic sum_d;
    logic out_load;
  } cmd_t;

endpackage

// File: sv/ppidfd_if.sv
// Request channel interfaces for the error samples and the drive values.
`timescale 1ns / 1ps

interface ppidfd_err_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ppidfd_pkg::SAMPLE_W-1:0] err_sample;

  modport source (output valid, output err_sample, input ready);
  modport sink (input valid, input err_sample, output ready);
endinterface

interface ppidfd_drive_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ppidfd_pkg::SAMPLE_W-1:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink (input valid, input drive_value, output ready);
endinterface

// File: sv/ppidfd_regs.sv
// Configuration register file for gains, filter weight and clamp limits.
`timescale 1ns / 1ps

module ppidfd_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ppidfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppidfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output ppidfd_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{prop_gain:    '0,
               integ_gain:   '0,
               deriv_gain:   '0,
               filter_coeff: '0,
               prop_limit:   '0,
               integ_bound:  '1,
               deriv_limit:  '0,
               out_limit:    '0};
    end else if (cfg_we) begin
      case (ppidfd_pkg::cfg_idx_t'(cfg_index))
        ppidfd_pkg::REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[ppidfd_pkg::GAIN_W-1:0];
        ppidfd_pkg::REG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data[ppidfd_pkg::GAIN_W-1:0];
        ppidfd_pkg::REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[ppidfd_pkg::GAIN_W-1:0];
        ppidfd_pkg::REG_FILTER_COEFF: cfg.filter_coeff <= cfg_data[ppidfd_pkg::COEF_W-1:0];
        ppidfd_pkg::REG_PROP_LIMIT:   cfg.prop_limit   <= cfg_data[ppidfd_pkg::LIM_W-1:0];
        ppidfd_pkg::REG_INTEG_BOUND:  cfg.integ_bound  <= cfg_data[ppidfd_pkg::LIM_W-1:0];
        ppidfd_pkg::REG_DERIV_LIMIT:  cfg.deriv_limit  <= cfg_data[ppidfd_pkg::LIM_W-1:0];
        ppidfd_pkg::REG_OUT_LIMIT:    cfg.out_limit    <= cfg_data[ppidfd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/ppidfd_ctrl.sv
// Controller state machine that sequences one request through the shared datapath.
`timescale 1ns / 1ps

module ppidfd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ppidfd_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PRE    = 9'b000000010,
    S_LOAD   = 9'b000000100,
    S_MLO    = 9'b000001000,
    S_MHI    = 9'b000010000,
    S_SUM_PI = 9'b000100000,
    S_WAIT_D = 9'b001000000,
    S_SUM_D  = 9'b010000000,
    S_FINAL  = 9'b100000000
  } state_t;

  state_t           state, state_next;
  ppidfd_pkg::op_t  op, op_next;
  logic             out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    op_next    = op;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.ld_en  = 1'b1;
        cmd.ld_op  = ppidfd_pkg::OP_DA;
        cmd.iclamp = 1'b1;
        op_next    = ppidfd_pkg::OP_DA;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.lo_en  = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        // The next operand pair loads while the upper half is multiplied.
        cmd.hi_en = 1'b1;
        if (op == ppidfd_pkg::OP_DF) begin
          state_next = S_SUM_PI;
        end else begin
          case (op)
            ppidfd_pkg::OP_DA: op_next = ppidfd_pkg::OP_FB;
            ppidfd_pkg::OP_FB: op_next = ppidfd_pkg::OP_PE;
            ppidfd_pkg::OP_PE: op_next = ppidfd_pkg::OP_IA;
            ppidfd_pkg::OP_IA: op_next = ppidfd_pkg::OP_DF;
            default:           op_next = ppidfd_pkg::OP_DA;
          endcase
          cmd.ld_en  = 1'b1;
          cmd.ld_op  = op_next;
          state_next = S_MLO;
        end
      end
      S_SUM_PI: begin
        cmd.sum_pi = 1'b1;
        state_next = S_WAIT_D;
      end
      S_WAIT_D: begin
        state_next = S_SUM_D;
      end
      S_SUM_D: begin
        cmd.sum_d  = 1'b1;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= ppidfd_pkg::OP_DA;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/ppidfd_dpath.sv
// Datapath: controller state terms, shared split multiplier, saturation and clamps.
`timescale 1ns / 1ps

module ppidfd_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppidfd_pkg::cfg_t                       cfg,
  input  ppidfd_pkg::cmd_t                       cmd,
  input  logic signed [ppidfd_pkg::SAMPLE_W-1:0] err_sample,
  output logic signed [ppidfd_pkg::SAMPLE_W-1:0] drive_value
);

  localparam int AW = ppidfd_pkg::ACC_WIDTH;
  localparam int BW = ppidfd_pkg::MAG_B_W;
  localparam int HW = ppidfd_pkg::HALF_W;

  localparam ppidfd_pkg::acc_t ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam ppidfd_pkg::acc_t ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [BW-1:0]    ONE_B   = BW'(1) << ppidfd_pkg::FRAC_BITS;

  function automatic ppidfd_pkg::acc_t sat_wide(input logic [AW:0] v);
    if (v[AW] != v[AW-1]) begin
      return v[AW] ? ACC_MIN : ACC_MAX;
    end
    return ppidfd_pkg::acc_t'(v[AW-1:0]);
  endfunction

  function automatic ppidfd_pkg::acc_t sat_add(input ppidfd_pkg::acc_t x,
                                               input ppidfd_pkg::acc_t y);
    logic [AW:0] s;
    s = {x[AW-1], x} + {y[AW-1], y};
    return sat_wide(s);
  endfunction

  function automatic ppidfd_pkg::acc_t sat_sub(input ppidfd_pkg::acc_t x,
                                               input ppidfd_pkg::acc_t y);
    logic [AW:0] s;
    s = {x[AW-1], x} - {y[AW-1], y};
    return sat_wide(s);
  endfunction

  function automatic ppidfd_pkg::acc_t clamp_sym(input ppidfd_pkg::acc_t x,
                                                 input logic [ppidfd_pkg::LIM_W-1:0] lim);
    ppidfd_pkg::acc_t l;
    ppidfd_pkg::acc_t nl;
    l  = ppidfd_pkg::acc_t'(lim);
    nl = -l;
    if (x > l) begin
      return l;
    end else if (x < nl) begin
      return nl;
    end
    return x;
  endfunction

  function automatic logic [BW:0] gain_ext(input logic [ppidfd_pkg::GAIN_W-1:0] g);
    return {{(BW + 1 - ppidfd_pkg::GAIN_W){g[ppidfd_pkg::GAIN_W-1]}}, g};
  endfunction

  // Controller state terms and per-request temporaries.
  ppidfd_pkg::acc_t e_reg, d_in, integ_accum, last_prop_term, filtered_deriv;
  ppidfd_pkg::acc_t m0, i_term, p_term, d_term, s_pi, s_all;

  // Multiplier pipeline.
  logic [AW-1:0]                  mag_a;
  logic [BW-1:0]                  mag_b;
  logic                           ld_neg;
  ppidfd_pkg::op_t                ld_tag;
  logic [ppidfd_pkg::PP_W-1:0]    pp_lo;
  logic [ppidfd_pkg::PROD_W-1:0]  prod;
  logic                           prod_neg;
  ppidfd_pkg::op_t                prod_tag;
  logic                           fin_en;
  ppidfd_pkg::acc_t               mres;
  ppidfd_pkg::op_t                mres_tag;
  logic                           wb_en;

  logic [BW-1:0]                  coef_ext, coef, coef_comp;
  ppidfd_pkg::acc_t               opnd_a;
  logic [BW:0]                    opnd_b;
  logic [AW-1:0]                  abs_a;
  logic [BW:0]                    abs_b;
  logic [HW-1:0]                  mul_x;
  logic [ppidfd_pkg::PP_W-1:0]    mul_p;
  logic [ppidfd_pkg::QUOT_W-1:0]  quot;
  logic                           quot_big;
  ppidfd_pkg::acc_t               fin_val;
  ppidfd_pkg::acc_t               drive_next;

  // Operand selection and sign/magnitude split.
  always_comb begin
    coef_ext  = BW'(cfg.filter_coeff);
    coef      = (coef_ext > ONE_B) ? ONE_B : coef_ext;
    coef_comp = ONE_B - coef;
    case (cmd.ld_op)
      ppidfd_pkg::OP_DA: begin
        opnd_a = d_in;
        opnd_b = {1'b0, coef};
      end
      ppidfd_pkg::OP_FB: begin
        opnd_a = filtered_deriv;
        opnd_b = {1'b0, coef_comp};
      end
      ppidfd_pkg::OP_PE: begin
        opnd_a = e_reg;
        opnd_b = gain_ext(cfg.prop_gain);
      end
      ppidfd_pkg::OP_IA: begin
        opnd_a = integ_accum;
        opnd_b = gain_ext(cfg.integ_gain);
      end
      ppidfd_pkg::OP_DF: begin
        opnd_a = filtered_deriv;
        opnd_b = gain_ext(cfg.deriv_gain);
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
    abs_a = opnd_a[AW-1] ? (~opnd_a + 1'b1) : opnd_a;
    abs_b = opnd_b[BW]   ? (~opnd_b + 1'b1) : opnd_b;
  end

  // One multiplier takes the lower half of the first operand, then the upper half.
  assign mul_x = cmd.hi_en ? HW'(mag_a[AW-1:HW]) : mag_a[HW-1:0];
  assign mul_p = mul_x * mag_b;

  // Truncate the magnitude toward zero, then saturate and restore the sign.
  always_comb begin
    quot     = prod[ppidfd_pkg::PROD_W-1:ppidfd_pkg::FRAC_BITS];
    quot_big = |quot[ppidfd_pkg::QUOT_W-1:AW-1];
    if (!prod_neg) begin
      fin_val = quot_big ? ACC_MAX : ppidfd_pkg::acc_t'(quot[AW-1:0]);
    end else begin
      fin_val = quot_big ? ACC_MIN : -ppidfd_pkg::acc_t'(quot[AW-1:0]);
    end
  end

  assign drive_next = clamp_sym(s_all, cfg.out_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_accum    <= '0;
      last_prop_term <= '0;
      filtered_deriv <= '0;
      fin_en         <= 1'b0;
      wb_en          <= 1'b0;
    end else begin
      fin_en <= cmd.hi_en;
      wb_en  <= fin_en;
      if (cmd.pre) begin
        integ_accum <= sat_add(integ_accum, e_reg);
      end else if (cmd.iclamp && (cfg.integ_gain != '0)) begin
        integ_accum <= clamp_sym(integ_accum, cfg.integ_bound);
      end
      if (wb_en) begin
        case (mres_tag)
          ppidfd_pkg::OP_FB: filtered_deriv <= sat_add(m0, mres);
          ppidfd_pkg::OP_PE: last_prop_term <= mres;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      e_reg <= ppidfd_pkg::acc_t'(err_sample);
    end
    if (cmd.pre) begin
      d_in <= sat_sub(e_reg, last_prop_term);
    end
    if (cmd.ld_en) begin
      mag_a  <= abs_a;
      mag_b  <= abs_b[BW-1:0];
      ld_neg <= opnd_a[AW-1] ^ opnd_b[BW];
      ld_tag <= cmd.ld_op;
    end
    if (cmd.lo_en) begin
      pp_lo <= mul_p;
    end
    if (cmd.hi_en) begin
      prod     <= ppidfd_pkg::PROD_W'(pp_lo) + (ppidfd_pkg::PROD_W'(mul_p) << HW);
      prod_neg <= ld_neg;
      prod_tag <= ld_tag;
    end
    if (fin_en) begin
      mres     <= fin_val;
      mres_tag <= prod_tag;
    end
    if (wb_en) begin
      case (mres_tag)
        ppidfd_pkg::OP_DA: m0 <= mres;
        ppidfd_pkg::OP_IA: begin
          i_term <= mres;
          p_term <= clamp_sym(last_prop_term, cfg.prop_limit);
        end
        ppidfd_pkg::OP_DF: d_term <= clamp_sym(mres, cfg.deriv_limit);
        default: ;
      endcase
    end
    if (cmd.sum_pi) begin
      s_pi <= sat_add(p_term, i_term);
    end
    if (cmd.sum_d) begin
      s_all <= sat_add(s_pi, d_term);
    end
    if (cmd.out_load) begin
      drive_value <= drive_next[ppidfd_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

// File: sv/positional_pid_filtered_derivative.sv
// The drive value is registered in S_FINAL, after S_PRE, S_LOAD, the S_MLO/S_MHI passes,
// S_SUM_PI, S_WAIT_D and S_SUM_D; five products share one multiplier, two passes each.
// Only then is the next request taken; the drive value waits in the output register. Reset
// (rst, synchronous, active high) zeroes the P, D and I state, controller and config registers,
// except the integral bound, set to its maximum; other datapath registers are not reset.
`timescale 1ns / 1ps

module positional_pid_filtered_derivative (
  input  logic                              clk,
  input  logic                              rst,
  ppidfd_err_if.sink                        err_ch,
  ppidfd_drive_if.source                    drive_ch,
  input  logic                              cfg_we,
  input  logic [ppidfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppidfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  ppidfd_pkg::cfg_t cfg;
  ppidfd_pkg::cmd_t cmd;

  ppidfd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppidfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (err_ch.valid),
    .in_ready  (err_ch.ready),
    .out_valid (drive_ch.valid),
    .out_ready (drive_ch.ready),
    .cmd       (cmd)
  );

  ppidfd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .err_sample  (err_ch.err_sample),
    .drive_value (drive_ch.drive_value)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the filtered-derivative PID block, with predicted drive values.
`timescale 1ns / 1ps
module testbench;
  import ppidfd_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     REG_COUNT   = 8;
  localparam int     ACCUM_PHASE = 5;
  localparam longint ACC_HI      = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_LO      = -ACC_HI - 1;
  localparam longint UNITY       = longint'(1) <<< FRAC_BITS;

  localparam logic [LIM_W-1:0]           LIM_MAX  = '1;
  localparam logic [COEF_W-1:0]          COEF_MAX = '1;
  localparam logic signed [GAIN_W-1:0]   GAIN_MAX = {1'b0, {(GAIN_W - 1){1'b1}}};
  localparam logic signed [GAIN_W-1:0]   GAIN_MIN = {1'b1, {(GAIN_W - 1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] ERR_MAX  = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] ERR_MIN  = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  // Holds the controller's own copy of settings and state, and the drive values still owed.
  class pid_drive_scoreboard;
    longint prop_gain, integ_gain, deriv_gain, filter_coeff;
    longint prop_limit, integ_bound, deriv_limit, out_limit;
    longint last_prop, filt_deriv, integ_acc;
    logic signed [SAMPLE_W-1:0] drive_due[$];
    int errors;

    function new();
      prop_gain    = 0;
      integ_gain   = 0;
      deriv_gain   = 0;
      filter_coeff = 0;
      prop_limit   = 0;
      integ_bound  = LIM_MAX;
      deriv_limit  = 0;
      out_limit    = 0;
      last_prop    = 0;
      filt_deriv   = 0;
      integ_acc    = 0;
      errors       = 0;
    endfunction

    function longint sat_acc(longint x, longint y);
      longint s;
      s = x + y;
      if (s > ACC_HI) return ACC_HI;
      if (s < ACC_LO) return ACC_LO;
      return s;
    endfunction

    function longint clamp_lim(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    // Exact product of magnitudes, shifted down (so truncated toward zero), then saturated.
    function longint mul_q(longint x, longint y);
      logic [127:0] ux, uy, q;
      bit neg;
      neg = (x < 0) != (y < 0);
      ux = (x < 0) ? -x : x;
      uy = (y < 0) ? -y : y;
      q = (ux * uy) >> FRAC_BITS;
      if (neg) return (q > ACC_HI) ? ACC_LO : -longint'(q[63:0]);
      return (q > ACC_HI) ? ACC_HI : longint'(q[63:0]);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      logic signed [GAIN_W-1:0] g;
      g = data[GAIN_W-1:0];
      case (idx)
        REG_PROP_GAIN:    prop_gain = g;
        REG_INTEG_GAIN:   integ_gain = g;
        REG_DERIV_GAIN:   deriv_gain = g;
        REG_FILTER_COEFF: filter_coeff = data[COEF_W-1:0];
        REG_PROP_LIMIT:   prop_limit = data[LIM_W-1:0];
        REG_INTEG_BOUND:  integ_bound = data[LIM_W-1:0];
        REG_DERIV_LIMIT:  deriv_limit = data[LIM_W-1:0];
        REG_OUT_LIMIT:    out_limit = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_error_sample(logic signed [SAMPLE_W-1:0] e_in);
      longint e, wt, d_in, p_term, i_term, d_term, total;
      e = e_in;
      wt = (filter_coeff > UNITY) ? UNITY : filter_coeff;
      // The derivative input subtracts the previous P term, not the previous error.
      d_in = sat_acc(e, -last_prop);
      filt_deriv = sat_acc(mul_q(d_in, wt), mul_q(filt_deriv, UNITY - wt));
      last_prop = mul_q(prop_gain, e);
      integ_acc = sat_acc(integ_acc, e);
      if (integ_gain != 0) integ_acc = clamp_lim(integ_acc, integ_bound);
      p_term = clamp_lim(last_prop, prop_limit);
      i_term = mul_q(integ_gain, integ_acc);
      d_term = clamp_lim(mul_q(deriv_gain, filt_deriv), deriv_limit);
      total = clamp_lim(sat_acc(sat_acc(p_term, i_term), d_term), out_limit);
      drive_due.push_back(total[SAMPLE_W-1:0]);
    endfunction

    function void check_drive(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (drive_due.size() == 0) begin
        errors++;
        $error("drive_value: expected nothing, actual %0d", got);
        return;
      end
      want = drive_due.pop_front();
      if (want !== got) begin
        errors++;
        $error("drive_value: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    no_idle;
  int                    cycles;
  pid_drive_scoreboard   sb;

  ppidfd_err_if   err_ch ();
  ppidfd_drive_if drive_ch ();

  positional_pid_filtered_derivative dut (
    .clk      (clk),
    .rst      (rst),
    .err_ch   (err_ch),
    .drive_ch (drive_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2: return '0;
      3, 4: return GAIN_W'(longint'($urandom_range(0, 4 * UNITY)) - 2 * UNITY);
      5: return $urandom_range(0, 1) ? GAIN_W'(UNITY) : -GAIN_W'(UNITY);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COEF_W'(UNITY);
      2: return COEF_MAX;
      3: return COEF_W'($urandom_range(UNITY + 1, COEF_MAX));
      default: return COEF_W'($urandom_range(0, UNITY));
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] rand_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return LIM_MAX;
      4: return LIM_W'($urandom_range(0, 4 * UNITY));
      default: return LIM_W'($urandom);
    endcase
  endfunction

  function automatic cfg_t make_setup(logic signed [GAIN_W-1:0] pg, logic signed [GAIN_W-1:0] ig,
                                      logic signed [GAIN_W-1:0] dg, logic [COEF_W-1:0] fc,
                                      logic [LIM_W-1:0] pl, logic [LIM_W-1:0] ib,
                                      logic [LIM_W-1:0] dl, logic [LIM_W-1:0] ol);
    cfg_t c;
    c.prop_gain    = pg;
    c.integ_gain   = ig;
    c.deriv_gain   = dg;
    c.filter_coeff = fc;
    c.prop_limit   = pl;
    c.integ_bound  = ib;
    c.deriv_limit  = dl;
    c.out_limit    = ol;
    return c;
  endfunction

  function automatic cfg_t random_setup();
    return make_setup(rand_gain(), rand_gain(), rand_gain(), rand_coeff(),
                      rand_limit(), rand_limit(), rand_limit(), rand_limit());
  endfunction

  // Error samples: full-range noise, small values, extremes and a slowly drifting signal.
  function automatic logic signed [SAMPLE_W-1:0] next_err(ref longint walk);
    longint v;
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) begin
      v = longint'($signed($urandom));
    end else if (r < 10) begin
      v = longint'($urandom_range(0, 8 * UNITY)) - 4 * UNITY;
    end else if (r < 12) begin
      case ($urandom_range(0, 4))
        0: v = ERR_MAX;
        1: v = ERR_MIN;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end else begin
      v = walk + longint'($urandom_range(0, 8192)) - 4096;
      if (v > ERR_MAX) v = ERR_MAX;
      if (v < ERR_MIN) v = ERR_MIN;
    end
    walk = v;
    return SAMPLE_W'(v);
  endfunction

  task automatic send_err(logic signed [SAMPLE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      err_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    err_ch.valid      <= 1'b1;
    err_ch.err_sample <= v;
    @(posedge clk);
    while (!err_ch.ready) @(posedge clk);
    sb.add_error_sample(v);
  endtask

  // Stop sending and wait until every owed drive value has come back.
  task automatic drain();
    err_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic load_setup(cfg_t c);
    logic [CFG_DATA_W-1:0] vals [REG_COUNT];
    vals[REG_PROP_GAIN]    = CFG_DATA_W'($unsigned(c.prop_gain));
    vals[REG_INTEG_GAIN]   = CFG_DATA_W'($unsigned(c.integ_gain));
    vals[REG_DERIV_GAIN]   = CFG_DATA_W'($unsigned(c.deriv_gain));
    vals[REG_FILTER_COEFF] = CFG_DATA_W'(c.filter_coeff);
    vals[REG_PROP_LIMIT]   = CFG_DATA_W'(c.prop_limit);
    vals[REG_INTEG_BOUND]  = CFG_DATA_W'(c.integ_bound);
    vals[REG_DERIV_LIMIT]  = CFG_DATA_W'(c.deriv_limit);
    vals[REG_OUT_LIMIT]    = CFG_DATA_W'(c.out_limit);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      sb.write_reg(cfg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : drive_sink
    int stall;
    int n;
    stall = 0;
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && drive_ch.valid && drive_ch.ready) sb.check_drive(drive_ch.drive_value);
      if (stall > 0) begin
        stall--;
        drive_ch.ready <= 1'b0;
      end else begin
        n = pick_gap();
        drive_ch.ready <= (n == 0);
        stall = (n > 0) ? n - 1 : 0;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    cfg_t   setup;
    longint walk;
    logic signed [SAMPLE_W-1:0] dir_a [10] = '{0, 1, -1, ERR_MAX, ERR_MIN, ERR_MAX, ERR_MIN,
                                               65536, -65536, 12345};
    logic signed [SAMPLE_W-1:0] dir_b [6]  = '{ERR_MAX, ERR_MAX, ERR_MIN, ERR_MIN, 0, 1};
    logic signed [SAMPLE_W-1:0] dir_c [5]  = '{ERR_MIN, ERR_MAX, -1, 32'sh0001_8000, 0};

    sb = new();
    walk = 0;
    no_idle = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_PROP_GAIN;
    cfg_data <= '0;
    err_ch.valid <= 1'b0;
    err_ch.err_sample <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Settings straight out of reset: zero gains and zero P, D and output limits, so the drive stays at zero.
    send_err(ERR_MAX);
    send_err(ERR_MIN);
    send_err(7);

    // Unity P gain, minus-unity D gain, zero integral gain and a filter weight above one.
    drain();
    load_setup(make_setup(GAIN_W'(UNITY), '0, -GAIN_W'(UNITY), COEF_MAX,
                          LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX));
    foreach (dir_a[k]) send_err(dir_a[k]);

    // Extreme gains with tight P and I clamps and the D term clamped away.
    drain();
    load_setup(make_setup(GAIN_MAX, GAIN_MIN, GAIN_MAX, '0,
                          LIM_W'(UNITY), LIM_W'(2 * UNITY), '0, LIM_MAX));
    foreach (dir_b[k]) send_err(dir_b[k]);

    drain();
    load_setup(make_setup(GAIN_MIN, GAIN_MAX, GAIN_MIN, COEF_W'(UNITY),
                          LIM_MAX, LIM_MAX, LIM_MAX, 31'h4000_0000));
    foreach (dir_c[k]) send_err(dir_c[k]);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      no_idle = (ph % 4 == 2);
      if (ph == 0)
        setup = make_setup(GAIN_MAX, GAIN_MAX, GAIN_MAX, COEF_MAX,
                           LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX);
      else if (ph == 1)
        setup = make_setup(GAIN_MIN, GAIN_MIN, GAIN_MIN, '0, LIM_MAX, '0, LIM_MAX, LIM_MAX);
      else
        setup = random_setup();
      if (ph == ACCUM_PHASE) begin
        // With no integral gain the accumulator is unclamped; push it toward saturation.
        setup.integ_gain = '0;
        setup.out_limit  = LIM_MAX;
        load_setup(setup);
        for (int k = 0; k < 300; k++) begin
          if (k < 270) send_err($signed($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)));
          else send_err($signed({1'b1, 31'($urandom)}));
        end
      end else begin
        load_setup(setup);
        repeat (66) send_err(next_err(walk));
      end
    end

    no_idle = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
sv/ppidfd_pkg.sv
sv/ppidfd_if.sv
sv/ppidfd_regs.sv
sv/ppidfd_ctrl.sv
sv/ppidfd_dpath.sv
sv/positional_pid_filtered_derivative.sv
tb/testbench.sv
